// ----- rtl/dtcf_pkg.sv -----
// ----------------------------------------------------------------------------
// Double to custom float package
// Shared widths, constants and register indexes of the double to custom float
// conversion unit.
// ----------------------------------------------------------------------------
package dtcf_pkg;

  localparam int unsigned DblW     = 64;
  localparam int unsigned DblExpW  = 11;
  localparam int unsigned DblFracW = 52;
  localparam int unsigned ExpBias  = 1023;

  localparam int unsigned TotW     = 7;
  localparam int unsigned ExpW     = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  localparam logic [TotW-1:0] TotReset = 7'd32;
  localparam logic [ExpW-1:0] ExpReset = 6'd8;

  localparam logic [CfgIdxW-1:0] CFG_TOTAL_BITS    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_EXPONENT_BITS = 1'b1;

  localparam int unsigned NumStages = 7;

  typedef logic [DblW-1:0]     dbl_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

endpackage

// ----- rtl/double_to_custom_float_unit.sv -----
// ----------------------------------------------------------------------------
// Double to custom float conversion unit
// Repacks a binary64 bit pattern into a float format of configurable total
// and exponent width, with half-up rounding of the fraction.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  cfg       cfg_valid_i/cfg_ready_o, index, data      in (register write)
//  in        in_valid_i/in_ready_o, double_bits_i      in (one value)
//  out       out_valid_o/out_ready_i, packed_value_o   out (one result)
//
// Seven register stages; a request is accepted in every cycle in which the
// input stage can advance, and its result passes through stages 0 to 6 to the
// output, where it is held while the output is stalled.
// Rate is one request per cycle unless stalled, set by the seven-stage pipeline.
// A stalled output holds its result; bubbles inside the pipeline still close up.
// Reset clears the valid bits and sets total_bits to 32 and exponent_bits to 8.
// The configuration port is always ready.
module double_to_custom_float_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  dtcf_pkg::cfg_idx_t  cfg_index_i,
  input  dtcf_pkg::cfg_data_t cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtcf_pkg::dbl_t      double_bits_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtcf_pkg::dbl_t      packed_value_o
);
  import dtcf_pkg::*;

  typedef enum logic [2:0] {
    CLS_NUM,
    CLS_INF,
    CLS_NAN,
    CLS_ZERO,
    CLS_UNF
  } cls_e;

  function automatic logic [3:0] lz13(input logic [12:0] x);
    logic [3:0] n;
    logic       found;
    n     = 4'd13;
    found = 1'b0;
    for (int i = 0; i < 13; i++) begin
      if (!found && x[12-i]) begin
        n     = 4'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Configuration registers and derived format constants.
  logic [TotW-1:0] total_q;
  logic [ExpW-1:0] expo_q;
  logic [TotW-1:0] tot_s, eb_lim, eb_s;
  logic [5:0]      fb_d, fb_q;
  logic [63:0]     erange64;
  logic [60:0]     bias_d, bias_q;
  logic [61:0]     erange_d, erange_q;
  dbl_t            inf_pat_d, inf_pat_q;
  dbl_t            sign_pat_d, sign_pat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotReset;
      expo_q  <= ExpReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TOTAL_BITS:    total_q <= cfg_data_i[TotW-1:0];
        CFG_EXPONENT_BITS: expo_q  <= cfg_data_i[ExpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (total_q < 7'd3) begin
      tot_s = 7'd3;
    end else if (total_q > 7'd64) begin
      tot_s = 7'd64;
    end else begin
      tot_s = total_q;
    end
    eb_lim = tot_s - 7'd2;
    if (expo_q == '0) begin
      eb_s = 7'd1;
    end else if ({1'b0, expo_q} > eb_lim) begin
      eb_s = eb_lim;
    end else begin
      eb_s = {1'b0, expo_q};
    end
    fb_d       = 6'(tot_s - eb_s - 7'd1);
    erange64   = (64'd1 << eb_s) - 64'd1;
    erange_d   = erange64[61:0];
    bias_d     = erange64[61:1];
    inf_pat_d  = erange64 << fb_d;
    sign_pat_d = 64'd1 << (tot_s - 7'd1);
  end

  always_ff @(posedge clk_i) begin
    fb_q       <= fb_d;
    bias_q     <= bias_d;
    erange_q   <= erange_d;
    inf_pat_q  <= inf_pat_d;
    sign_pat_q <= sign_pat_d;
  end

  // Pipeline flow control.
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: input register.
  dbl_t d0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d0_q <= double_bits_i;
    end
  end

  // Stage 1: decode and per-group leading zero counts.
  logic [DblExpW-1:0]  e0;
  logic [DblFracW-1:0] f0;
  cls_e                cls1_d, cls1_q;
  logic                sign1_q;
  logic [DblExpW-1:0]  e1_q;
  logic [DblFracW-1:0] f1_q;
  logic [3:0]          nz1_d, nz1_q;
  logic [3:0]          glz1_d [4];
  logic [3:0]          glz1_q [4];

  assign e0 = d0_q[DblW-2:DblFracW];
  assign f0 = d0_q[DblFracW-1:0];

  always_comb begin
    if (e0 == '1) begin
      cls1_d = (f0 != '0) ? CLS_NAN : CLS_INF;
    end else if (e0 == '0 && f0 == '0) begin
      cls1_d = CLS_ZERO;
    end else begin
      cls1_d = CLS_NUM;
    end
    for (int g = 0; g < 4; g++) begin
      nz1_d[g]  = (f0[51-13*g -: 13] != '0);
      glz1_d[g] = lz13(f0[51-13*g -: 13]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cls1_q  <= cls1_d;
      sign1_q <= d0_q[DblW-1];
      e1_q    <= e0;
      f1_q    <= f0;
      nz1_q   <= nz1_d;
      glz1_q  <= glz1_d;
    end
  end

  // Stage 2: normalise the significand.
  logic [5:0]          lz2;
  logic [52:0]         m2_d, m2_q;
  logic signed [11:0]  e2_d, e2_q;
  cls_e                cls2_q;
  logic                sign2_q;

  always_comb begin
    if (nz1_q[0]) begin
      lz2 = {2'b0, glz1_q[0]};
    end else if (nz1_q[1]) begin
      lz2 = 6'd13 + {2'b0, glz1_q[1]};
    end else if (nz1_q[2]) begin
      lz2 = 6'd26 + {2'b0, glz1_q[2]};
    end else begin
      lz2 = 6'd39 + {2'b0, glz1_q[3]};
    end
    if (e1_q == '0) begin
      m2_d = 53'({1'b0, f1_q} << (lz2 + 6'd1));
      e2_d = -$signed({6'b0, lz2});
    end else begin
      m2_d = {1'b1, f1_q};
      e2_d = $signed({1'b0, e1_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      m2_q    <= m2_d;
      e2_q    <= e2_d;
      cls2_q  <= cls1_q;
      sign2_q <= sign1_q;
    end
  end

  // Stage 3: re-bias the exponent.
  logic signed [63:0] exps3_d, exps3_q;
  logic [52:0]        m3_q;
  cls_e               cls3_q;
  logic               sign3_q;

  assign exps3_d = $signed({{52{e2_q[11]}}, e2_q}) - 64'sd1023
                 + $signed({3'b0, bias_q});

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      exps3_q <= exps3_d;
      m3_q    <= m2_q;
      cls3_q  <= cls2_q;
      sign3_q <= sign2_q;
    end
  end

  // Stage 4: range checks and shift amount.
  logic        ovf4, unf4, sub4;
  logic [7:0]  t8;
  logic [5:0]  t4_d, t4_q;
  logic [61:0] hib4_d, hib4_q;
  logic [63:0] expm1;
  cls_e        cls4_d, cls4_q;
  logic [52:0] m4_q;
  logic        sign4_q;

  always_comb begin
    ovf4  = exps3_q >= $signed({2'b0, erange_q});
    unf4  = exps3_q < -$signed({58'b0, fb_q});
    sub4  = exps3_q[63] || (exps3_q == '0);
    t8    = 8'd62 - {2'b0, fb_q} - exps3_q[7:0];
    expm1 = 64'(exps3_q) - 64'd1;
    if (sub4) begin
      t4_d   = t8[5:0];
      hib4_d = '0;
    end else begin
      t4_d   = 6'd61 - fb_q;
      hib4_d = expm1[61:0];
    end
    if (cls3_q != CLS_NUM) begin
      cls4_d = cls3_q;
    end else if (ovf4) begin
      cls4_d = CLS_INF;
    end else if (unf4) begin
      cls4_d = CLS_UNF;
    end else begin
      cls4_d = CLS_NUM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      t4_q    <= t4_d;
      hib4_q  <= hib4_d;
      cls4_q  <= cls4_d;
      m4_q    <= m3_q;
      sign4_q <= sign3_q;
    end
  end

  // Stage 5: align fraction and exponent.
  logic [62:0] z5_q;
  dbl_t        hi5_q;
  cls_e        cls5_q;
  logic        sign5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      z5_q    <= {m4_q, 10'b0} >> t4_q;
      hi5_q   <= {2'b0, hib4_q} << fb_q;
      cls5_q  <= cls4_q;
      sign5_q <= sign4_q;
    end
  end

  // Stage 6: round and assemble.
  logic [62:0] r6;
  dbl_t        num6;
  dbl_t        pv6_d, pv6_q;
  cls_e        cls6_q;

  always_comb begin
    r6    = {1'b0, z5_q[62:1]} + 63'(z5_q[0]);
    num6  = hi5_q + 64'(r6);
    pv6_d = '0;
    case (cls5_q)
      CLS_NUM:  pv6_d = (sign5_q ? sign_pat_q : '0) | num6;
      CLS_INF:  pv6_d = (sign5_q ? sign_pat_q : '0) | inf_pat_q;
      CLS_NAN:  pv6_d = inf_pat_q;
      CLS_UNF:  pv6_d = sign5_q ? sign_pat_q : '0;
      default:  pv6_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pv6_q  <= pv6_d;
      cls6_q <= cls5_q;
    end
  end

  assign out_valid_o    = v_q[NumStages-1];
  assign packed_value_o = pv6_q;

  // Results never carry bits above the configured format width.
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((packed_value_o & ~((sign_pat_q << 1) - 64'd1)) == '0))
    else $error("result has bits above the format width");

  // NaN and zero inputs give results without the sign bit.
  a_unsigned_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cls6_q == CLS_NAN || cls6_q == CLS_ZERO))
      |-> ((packed_value_o & sign_pat_q) == '0))
    else $error("NaN or zero result carries a sign");

  // An accepted request always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request lost at the input stage");

  // A stage that is full and cannot advance keeps its data; checked on stage 5.
  a_stage5_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[5] && !en[5]) |=> (v_q[5] && $stable(z5_q) && $stable(hi5_q)))
    else $error("stalled stage lost its data");

endmodule

// ----- sim/double_to_custom_float_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Double to custom float conversion unit testbench
// Streams binary64 patterns through the unit under a series of target formats
// and compares every packed result with a pinned table value or a behavioural
// conversion kept here. A short table of hand-picked values comes first, then
// random values, most aimed at the rounding, underflow and overflow boundaries
// of each format, with random gaps for requests and random stalls for results.
// ----------------------------------------------------------------------------
module double_to_custom_float_unit_tb;
  import dtcf_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned Settle        = NumStages + 3;
  localparam int unsigned NumPhases     = 14;
  localparam int unsigned ValuesPerPhase = 95;
  localparam int unsigned MaxReports    = 10;
  localparam longint FracW = DblFracW;
  localparam longint BiasD = ExpBias;

  typedef struct packed {
    dbl_t value;
    logic pinned;
    dbl_t want;
  } vector_t;

  typedef struct {
    dbl_t src;
    dbl_t want;
  } pending_t;

  // Rows run under the reset format of 32 bits with an 8-bit exponent.
  localparam vector_t Vectors [24] = '{
    '{64'h0000000000000000, 1'b1, 64'h0000000000000000},
    '{64'h8000000000000000, 1'b1, 64'h0000000000000000},
    '{64'h7FF0000000000000, 1'b1, 64'h000000007F800000},
    '{64'hFFF0000000000000, 1'b1, 64'h00000000FF800000},
    '{64'h7FF8000000000000, 1'b1, 64'h000000007F800000},
    '{64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h000000007F800000},
    '{64'h7FF0000000000001, 1'b1, 64'h000000007F800000},
    '{64'h3FF0000000000000, 1'b1, 64'h000000003F800000},
    '{64'hC000000000000000, 1'b1, 64'h00000000C0000000},
    '{64'h7FEFFFFFFFFFFFFF, 1'b1, 64'h000000007F800000},
    '{64'hFFEFFFFFFFFFFFFF, 1'b1, 64'h00000000FF800000},
    '{64'h0000000000000001, 1'b1, 64'h0000000000000000},
    '{64'h8000000000000001, 1'b1, 64'h0000000080000000},
    '{64'h000FFFFFFFFFFFFF, 1'b0, 64'h0},
    '{64'h3FF0000010000000, 1'b0, 64'h0},
    '{64'h3FF000000FFFFFFF, 1'b0, 64'h0},
    '{64'h3FFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{64'h47EFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{64'h47E0000000000000, 1'b0, 64'h0},
    '{64'h36A0000000000000, 1'b0, 64'h0},
    '{64'h3690000000000000, 1'b0, 64'h0},
    '{64'hB680000000000000, 1'b0, 64'h0},
    '{64'h3810000000000000, 1'b0, 64'h0},
    '{64'h380FFFFFFFFFFFFF, 1'b0, 64'h0}
  };

  // Total width and exponent width as written, out-of-range values included.
  localparam cfg_data_t Formats [10][2] = '{
    '{7'd64, 7'd11}, '{7'd3, 7'd1}, '{7'd64, 7'd1}, '{7'd64, 7'd62},
    '{7'd0, 7'd0}, '{7'd127, 7'd127}, '{7'd16, 7'd5}, '{7'd8, 7'd4},
    '{7'd12, 7'd20}, '{7'd40, 7'h48}
  };

  logic      clk_i;
  logic      rst_ni        = 1'b0;
  logic      cfg_valid_i   = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i   = CFG_TOTAL_BITS;
  cfg_data_t cfg_data_i    = '0;
  logic      in_valid_i    = 1'b0;
  logic      in_ready_o;
  dbl_t      double_bits_i = '0;
  logic      out_valid_o;
  logic      out_ready_i   = 1'b0;
  dbl_t      packed_value_o;

  logic            pin_flag = 1'b0;
  dbl_t            pin_value = '0;
  logic [TotW-1:0] total_reg = TotReset;
  logic [ExpW-1:0] exp_reg   = ExpReset;
  logic            calm      = 1'b0;

  pending_t    pending_q [$];
  pending_t    entry;
  int unsigned n_sent;
  int unsigned n_done;
  int unsigned n_errors;
  int unsigned n_formats;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned quiet_left;

  double_to_custom_float_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .double_bits_i  (double_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packed_value_o (packed_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  function automatic void format_of(output longint tot, output longint eb);
    tot = longint'(total_reg);
    eb  = longint'(exp_reg);
    if (tot < 3) tot = 3;
    if (tot > 64) tot = 64;
    if (eb < 1) eb = 1;
    if (eb > tot - 2) eb = tot - 2;
  endfunction

  function automatic logic [63:0] shift_half_up(logic [63:0] x, longint s);
    if (s <= 0) return x << (-s);
    return (x >> s) + ((x >> (s - 1)) & 64'd1);
  endfunction

  function automatic dbl_t to_custom(dbl_t d);
    longint      tot, eb, fb, bias, erange, e, exps;
    logic [63:0] frac, m, sign_bit, inf_code;
    logic        neg;
    format_of(tot, eb);
    fb       = tot - eb - 1;
    bias     = (longint'(1) << (eb - 1)) - 1;
    erange   = (longint'(1) << eb) - 1;
    frac     = {12'd0, d[51:0]};
    e        = longint'(d[62:52]);
    neg      = d[63];
    sign_bit = 64'd1 << (tot - 1);
    inf_code = 64'(erange) << fb;
    if (e == 2047) return (frac != 0 || !neg) ? inf_code : (sign_bit | inf_code);
    if (e == 0 && frac == 0) return '0;
    if (e == 0) begin
      e = 1;
      m = frac;
      while (m < (64'd1 << FracW)) begin
        m = m << 1;
        e = e - 1;
      end
    end else begin
      m = frac | (64'd1 << FracW);
    end
    frac = m & ((64'd1 << FracW) - 1);
    if (!neg) sign_bit = '0;
    exps = e - BiasD + bias;
    if (exps >= erange) return sign_bit | inf_code;
    if (exps <= 0) begin
      if (-exps > fb) return sign_bit;
      return sign_bit | shift_half_up(m, 53 - fb - exps);
    end
    return sign_bit | ((64'(exps) << fb) + shift_half_up(frac, FracW - fb));
  endfunction

  // Values cluster around the underflow and overflow edges of the current
  // format, and often sit exactly on or just below a rounding midpoint.
  function automatic dbl_t pick_value();
    longint      tot, eb, fb, bias, erange, exps, e, k;
    logic [63:0] frac, half;
    logic        neg;
    int unsigned kind;
    format_of(tot, eb);
    fb     = tot - eb - 1;
    bias   = (longint'(1) << (eb - 1)) - 1;
    erange = (longint'(1) << eb) - 1;
    kind   = $urandom_range(0, 99);
    neg    = 1'($urandom_range(0, 1));
    frac   = {$urandom, $urandom} & ((64'd1 << FracW) - 1);
    if (kind < 6) return {neg, 11'h7FF, (kind < 3) ? 52'd0 : frac[51:0]};
    if (kind < 10) return {neg, 11'h000, (kind < 7) ? 52'd0 : frac[51:0]};
    if (kind < 22) return {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0:       exps = -fb - 2 + longint'($urandom_range(0, 32'(fb + 4)));
      1:       exps = erange - 2 + longint'($urandom_range(0, 3));
      default: exps = longint'($urandom_range(1, 2046)) - BiasD + bias;
    endcase
    e = exps + BiasD - bias;
    k = FracW - fb;
    if (k > 0 && $urandom_range(0, 2) == 0) begin
      half = 64'd1 << (k - 1);
      frac = (frac & ~((half << 1) - 1)) | ($urandom_range(0, 1) ? half : half - 1);
    end
    if (e < 1) return {neg, 11'h000, frac[51:0]};
    if (e > 2046) e = 2046;
    return {neg, e[10:0], frac[51:0]};
  endfunction

  task automatic send_value(dbl_t value, logic pinned, dbl_t want);
    in_valid_i    <= 1'b1;
    double_bits_i <= value;
    pin_flag      <= pinned;
    pin_value     <= want;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_format(cfg_data_t tot_data, cfg_data_t exp_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TOTAL_BITS;
    cfg_data_i  <= tot_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_EXPONENT_BITS;
    cfg_data_i  <= exp_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_formats++;
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      entry.src  = double_bits_i;
      entry.want = pin_flag ? pin_value : to_custom(double_bits_i);
      pending_q.push_back(entry);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_TOTAL_BITS) begin
        total_reg = cfg_data_i[TotW-1:0];
      end else begin
        exp_reg = cfg_data_i[ExpW-1:0];
      end
    end
    if (out_valid_o && out_ready_i) begin
      n_done++;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) begin
          $display("unexpected result %h with no request pending", packed_value_o);
        end
      end else begin
        entry = pending_q.pop_front();
        if (packed_value_o !== entry.want) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("mismatch for %h: expected %h, got %h", entry.src, entry.want,
                     packed_value_o);
          end
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(20, 80);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    cfg_data_t tot_data, exp_data;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (Vectors[i]) begin
      send_value(Vectors[i].value, Vectors[i].pinned, Vectors[i].want);
    end
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph < $size(Formats)) begin
        tot_data = Formats[ph][0];
        exp_data = Formats[ph][1];
      end else begin
        tot_data = cfg_data_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(3, 64));
        exp_data = cfg_data_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 20));
      end
      set_format(tot_data, exp_data);
      if (ph >= NumPhases - 2) calm = 1'b1;
      for (int unsigned k = 0; k < ValuesPerPhase; k++) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk_i);
        end
        send_value(pick_value(), 1'b0, '0);
      end
    end
    drain();
    if (pending_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", pending_q.size());
    end
    $display("Converted %0d values under the reset format and %0d written formats.",
             n_done, n_formats);
    $display("Request gaps and result stalls were random, %0d mismatches seen.", n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
